### hw/rtl/tsca_pkg.sv
// Shared types, codes and the next-state rule of the three-state cell grid engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package tsca_pkg;

  localparam int GRID_WIDTH_DEF  = 128;
  localparam int GRID_HEIGHT_DEF = 128;
  localparam int COORD_W         = 7;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_COMMIT  = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  localparam logic [1:0] ST_OFF   = 2'd0;
  localparam logic [1:0] ST_ON    = 2'd1;
  localparam logic [1:0] ST_DYING = 2'd2;

  localparam logic [3:0] BIRTH_COUNT = 4'd2;

  // Neighbour offset codes: minus one, zero, plus one.
  localparam logic [1:0] OFS_LO  = 2'd0;
  localparam logic [1:0] OFS_MID = 2'd1;
  localparam logic [1:0] OFS_HI  = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [1:0]         cell_value;
  } tsca_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic [1:0]         cell_state;
    logic [3:0]         live_neighbours;
  } tsca_out_t;

  function automatic logic [1:0] next_cell(input logic [1:0] cs, input logic [3:0] n);
    logic [1:0] ns;
    ns = ST_OFF;
    if (cs == ST_OFF && n == BIRTH_COUNT) begin
      ns = ST_ON;
    end else if (cs == ST_ON) begin
      ns = ST_DYING;
    end
    return ns;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/tsca_bank.sv
// One generation bank: single-port cell memory with registered read data.
// Depends on tsca_pkg for the default grid size.
`default_nettype none

module tsca_bank #(
  parameter int DEPTH = tsca_pkg::GRID_WIDTH_DEF * tsca_pkg::GRID_HEIGHT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [1:0]    wdata,
  output logic [1:0]    rdata
);
  import tsca_pkg::*;

  logic [1:0] mem [DEPTH];
  logic [1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hw/rtl/tsca_nbr.sv
// Neighbour address unit: wraps the center row/column by an offset code and forms
// the linear cell address. Depends on tsca_pkg for the offset codes.
`default_nettype none

module tsca_nbr #(
  parameter int GRID_WIDTH  = tsca_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = tsca_pkg::GRID_HEIGHT_DEF,
  parameter int CW          = $clog2(GRID_WIDTH),
  parameter int RW          = $clog2(GRID_HEIGHT),
  parameter int AW          = $clog2(GRID_WIDTH * GRID_HEIGHT)
) (
  input  logic [CW-1:0] col,
  input  logic [RW-1:0] row,
  input  logic [1:0]    dc,
  input  logic [1:0]    dr,
  output logic [AW-1:0] addr
);
  import tsca_pkg::*;

  localparam logic [CW-1:0] COL_LAST = CW'(GRID_WIDTH - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(GRID_HEIGHT - 1);

  logic [CW-1:0] nc;
  logic [RW-1:0] nr;

  always_comb begin
    case (dc)
      OFS_LO:  nc = (col == '0) ? COL_LAST : CW'(col - CW'(1));
      OFS_HI:  nc = (col == COL_LAST) ? '0 : CW'(col + CW'(1));
      default: nc = col;
    endcase
    case (dr)
      OFS_LO:  nr = (row == '0) ? ROW_LAST : RW'(row - RW'(1));
      OFS_HI:  nr = (row == ROW_LAST) ? '0 : RW'(row + RW'(1));
      default: nr = row;
    endcase
  end

  assign addr = AW'(AW'(nr) * AW'(GRID_WIDTH)) + AW'(nc);

endmodule

`default_nettype wire

### hw/rtl/three_state_cellular_automaton_step.sv
// Three-state cell grid engine on a wrapped GRID_WIDTH x GRID_HEIGHT torus, two banks.
// Depends on tsca_pkg, tsca_nbr and tsca_bank.
//
// After reset both banks are swept to off, one cell per cycle, so in_ready stays low
// until all GRID_WIDTH*GRID_HEIGHT cells (16384 at the default size) are cleared. A
// commit beat flips the current bank and leaves in_ready high, a write beat writes one
// cell of the current bank, a read beat reads the target cell, and a compute beat makes
// nine reads of the target and its neighbours through the single port of the current
// bank, one read per cycle, then takes the last read data and hands off the result.
// Coordinates are reduced modulo the grid size and the reduced values are reported.
// A result waits in an output register, so the next beat may be accepted meanwhile;
// a later result that finds that register still full holds the block until out_ready.
`default_nettype none

module three_state_cellular_automaton_step #(
  parameter int GRID_WIDTH  = tsca_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = tsca_pkg::GRID_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tsca_pkg::tsca_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tsca_pkg::tsca_out_t out_data
);
  import tsca_pkg::*;

  localparam int DEPTH   = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(GRID_WIDTH);
  localparam int RW      = $clog2(GRID_HEIGHT);
  localparam int COORD_N = 1 << COORD_W;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_WRT   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_TAIL  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [1:0]    op_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [1:0]    val_r;
  logic [1:0]    dr_r, dr_nxt;
  logic [1:0]    dc_r, dc_nxt;
  logic [3:0]    cnt_r;
  logic [1:0]    cs_r;
  logic          rd_vld_r, rd_vld_nxt;
  logic          rd_ctr_r, rd_ctr_nxt;
  logic          sel_r, sel_nxt;
  logic [AW-1:0] clr_r;
  tsca_out_t     res_r, res_nxt;
  tsca_out_t     out_r;
  logic          out_valid_r, out_valid_nxt;

  logic [CW-1:0] col_tab [COORD_N];
  logic [RW-1:0] row_tab [COORD_N];

  logic          accept;
  logic          last_step;
  logic          load_out;
  logic [AW-1:0] nbr_addr;
  logic [AW-1:0] addr_mem;
  logic [1:0]    rd_a, rd_b, rd_cur;
  logic          we_cur, we_nxt, clearing;
  logic          we_a, we_b;
  logic [1:0]    wd_a, wd_b;
  logic [1:0]    wval;
  logic [1:0]    cs_fin, ns;
  logic [3:0]    cnt_fin;

  // Coordinate reduction tables, built at elaboration.
  for (genvar i = 0; i < COORD_N; i++) begin : g_tab
    assign col_tab[i] = CW'(i % GRID_WIDTH);
    assign row_tab[i] = RW'(i % GRID_HEIGHT);
  end

  tsca_nbr #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT),
    .CW         (CW),
    .RW         (RW),
    .AW         (AW)
  ) u_nbr (
    .col (col_r),
    .row (row_r),
    .dc  (dc_r),
    .dr  (dr_r),
    .addr(nbr_addr)
  );

  assign clearing = (state_r == S_CLEAR);
  assign addr_mem = clearing ? clr_r : nbr_addr;
  assign we_cur   = (state_r == S_WRT);
  assign we_nxt   = (state_r == S_TAIL) && (op_r == OP_COMPUTE);
  assign we_a     = clearing || (we_cur && !sel_r) || (we_nxt && sel_r);
  assign we_b     = clearing || (we_cur && sel_r) || (we_nxt && !sel_r);
  assign wval     = (val_r > ST_DYING) ? ST_OFF : val_r;
  assign wd_a     = clearing ? ST_OFF : (sel_r ? ns : wval);
  assign wd_b     = clearing ? ST_OFF : (sel_r ? wval : ns);
  assign rd_cur   = sel_r ? rd_b : rd_a;

  tsca_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank_a (
    .clk  (clk),
    .we   (we_a),
    .addr (addr_mem),
    .wdata(wd_a),
    .rdata(rd_a)
  );

  tsca_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank_b (
    .clk  (clk),
    .we   (we_b),
    .addr (addr_mem),
    .wdata(wd_b),
    .rdata(rd_b)
  );

  assign cnt_fin = cnt_r + 4'((rd_vld_r && !rd_ctr_r && rd_cur == ST_ON) ? 1 : 0);
  assign cs_fin  = (rd_vld_r && rd_ctr_r) ? rd_cur : cs_r;
  assign ns      = next_cell(cs_fin, cnt_fin);

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign last_step = (op_r == OP_READ) || (dr_r == OFS_HI && dc_r == OFS_HI);
  assign load_out  = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    dr_nxt        = dr_r;
    dc_nxt        = dc_r;
    rd_vld_nxt    = 1'b0;
    rd_ctr_nxt    = 1'b0;
    sel_nxt       = sel_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
    case (state_r)
      S_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          dr_nxt = (in_data.operation == OP_COMPUTE) ? OFS_LO : OFS_MID;
          dc_nxt = (in_data.operation == OP_COMPUTE) ? OFS_LO : OFS_MID;
          case (in_data.operation)
            OP_WRITE:  state_nxt = S_WRT;
            OP_COMMIT: sel_nxt   = !sel_r;
            default:   state_nxt = S_SCAN;
          endcase
        end
      end
      S_WRT: begin
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        rd_vld_nxt = 1'b1;
        rd_ctr_nxt = (dr_r == OFS_MID) && (dc_r == OFS_MID);
        if (last_step) begin
          dr_nxt    = OFS_MID;
          dc_nxt    = OFS_MID;
          state_nxt = S_TAIL;
        end else if (dc_r == OFS_HI) begin
          dc_nxt = OFS_LO;
          dr_nxt = dr_r + 2'd1;
        end else begin
          dc_nxt = dc_r + 2'd1;
        end
      end
      S_TAIL: begin
        res_nxt.out_col = COORD_W'(col_r);
        res_nxt.out_row = COORD_W'(row_r);
        if (op_r == OP_COMPUTE) begin
          res_nxt.cell_state      = ns;
          res_nxt.live_neighbours = cnt_fin;
        end else begin
          res_nxt.cell_state      = cs_fin;
          res_nxt.live_neighbours = 4'd0;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      dr_r        <= OFS_MID;
      dc_r        <= OFS_MID;
      rd_vld_r    <= 1'b0;
      rd_ctr_r    <= 1'b0;
      sel_r       <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dr_r        <= dr_nxt;
      dc_r        <= dc_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_ctr_r    <= rd_ctr_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
      if (clearing) begin
        clr_r <= AW'(clr_r + AW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (accept) begin
      op_r  <= in_data.operation;
      col_r <= col_tab[in_data.col];
      row_r <= row_tab[in_data.row];
      val_r <= in_data.cell_value;
      cnt_r <= 4'd0;
      cs_r  <= ST_OFF;
    end else if (rd_vld_r) begin
      if (rd_ctr_r) begin
        cs_r <= rd_cur;
      end else if (rd_cur == ST_ON) begin
        cnt_r <= cnt_r + 4'd1;
      end
    end
    if (load_out) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
